// File: rtl/prt_pkg.sv
// Package for the prescaled reload timer: request and response beat types,
// request and register codes, the period table and the remainder saturation.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
`default_nettype none

package prt_pkg;

  // Widths fixed by the bus format.
  localparam int unsigned DataW = 8;
  localparam int unsigned RemW  = 12;
  localparam int unsigned SumW  = RemW + 1;

  // Saturation bounds of the prescale remainder.
  localparam logic signed [SumW-1:0] RemMinWide = -13'sd2048;
  localparam logic signed [RemW-1:0] RemMin     = -12'sd2048;
  localparam logic signed [RemW-1:0] RemMax     = 12'sd2047;
  localparam logic signed [SumW-1:0] RemMaxWide = 13'sd2047;

  // Request codes; the fourth code is unused and does nothing.
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2
  } req_e;

  // Register select codes; the fourth code reads as zero and ignores writes.
  typedef enum logic [1:0] {
    SEL_COUNT   = 2'd0,
    SEL_MODULO  = 2'd1,
    SEL_CONTROL = 2'd2
  } sel_e;

  // Control register layout.
  localparam int unsigned CtrlEnBit = 2;

  // Request beat.
  typedef struct packed {
    logic [1:0]       req_type;
    logic [1:0]       reg_select;
    logic [DataW-1:0] write_data;
    logic [DataW-1:0] elapsed_cycles;
  } req_t;

  // Response beat.
  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             overflow_irq;
  } rsp_t;

  // Result of one prescaler step, handed from the prescaler to the registers.
  typedef struct packed {
    logic signed [RemW-1:0] rem;
    logic                   advance;
  } step_t;

  // Prescale period for each clock select code.
  function automatic logic signed [SumW-1:0] period_of(logic [1:0] sel);
    logic signed [SumW-1:0] p;
    case (sel)
      2'd0:    p = 13'sd1024;
      2'd1:    p = 13'sd16;
      2'd2:    p = 13'sd64;
      default: p = 13'sd256;
    endcase
    return p;
  endfunction

  // Saturate a widened remainder back into its register range.
  function automatic logic signed [RemW-1:0] sat_rem(logic signed [SumW-1:0] v);
    logic signed [RemW-1:0] r;
    if (v < RemMinWide) begin
      r = RemMin;
    end else if (v > RemMaxWide) begin
      r = RemMax;
    end else begin
      r = v[RemW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/prt_prescale.sv
// Prescaler step: subtracts elapsed cycles from the remainder, detects expiry
// and adds the selected period back. Purely combinational; uses prt_pkg.
`default_nettype none

module prt_prescale (
  input  logic signed [prt_pkg::RemW-1:0]  rem_i,
  input  logic        [prt_pkg::DataW-1:0] elapsed_i,
  input  logic        [1:0]                period_sel_i,
  output prt_pkg::step_t                   step_o
);

  logic signed [prt_pkg::SumW-1:0] diff;
  logic signed [prt_pkg::RemW-1:0] rem_sub;
  logic signed [prt_pkg::SumW-1:0] sum;
  logic                            expired;

  // Subtract the elapsed cycles and saturate.
  assign diff    = {rem_i[prt_pkg::RemW-1], rem_i}
                 - $signed({{(prt_pkg::SumW-prt_pkg::DataW){1'b0}}, elapsed_i});
  assign rem_sub = prt_pkg::sat_rem(diff);

  // The period expires at zero or below; reload adds one period back.
  assign expired = rem_sub[prt_pkg::RemW-1] || (rem_sub == '0);
  assign sum     = {rem_sub[prt_pkg::RemW-1], rem_sub} + prt_pkg::period_of(period_sel_i);

  always_comb begin
    step_o.advance = expired;
    step_o.rem     = expired ? prt_pkg::sat_rem(sum) : rem_sub;
  end

endmodule

`default_nettype wire

// File: rtl/prt_regs.sv
// Timer register file: counter, reload modulo, control and prescale remainder,
// with the bus decode and the read mux. Uses prt_pkg and prt_prescale.
`default_nettype none

module prt_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  prt_pkg::req_t req_i,
  output prt_pkg::rsp_t rsp_o
);

  logic [prt_pkg::DataW-1:0]        count_q, count_d;
  logic [prt_pkg::DataW-1:0]        modulo_q, modulo_d;
  logic                             enable_q, enable_d;
  logic [1:0]                       period_sel_q, period_sel_d;
  logic signed [prt_pkg::RemW-1:0]  rem_q, rem_d;
  prt_pkg::step_t                   step;
  logic                             wrap;

  prt_prescale u_prescale (
    .rem_i        (rem_q),
    .elapsed_i    (req_i.elapsed_cycles),
    .period_sel_i (period_sel_q),
    .step_o       (step)
  );

  assign wrap = (count_q == {prt_pkg::DataW{1'b1}});

  // Decode the request into next state and the response beat.
  always_comb begin
    count_d      = count_q;
    modulo_d     = modulo_q;
    enable_d     = enable_q;
    period_sel_d = period_sel_q;
    rem_d        = rem_q;
    rsp_o        = '0;
    unique case (req_i.req_type)
      prt_pkg::REQ_TICK: begin
        if (enable_q) begin
          rem_d = step.rem;
          if (step.advance) begin
            count_d            = wrap ? modulo_q : count_q + 1'b1;
            rsp_o.overflow_irq = wrap;
          end
        end
      end
      prt_pkg::REQ_READ: begin
        unique case (req_i.reg_select)
          prt_pkg::SEL_COUNT:   rsp_o.read_data = count_q;
          prt_pkg::SEL_MODULO:  rsp_o.read_data = modulo_q;
          prt_pkg::SEL_CONTROL: begin
            rsp_o.read_data[prt_pkg::CtrlEnBit] = enable_q;
            rsp_o.read_data[1:0]                = period_sel_q;
          end
          default: rsp_o.read_data = '0;
        endcase
      end
      prt_pkg::REQ_WRITE: begin
        unique case (req_i.reg_select)
          prt_pkg::SEL_COUNT:   count_d = req_i.write_data;
          prt_pkg::SEL_MODULO:  modulo_d = req_i.write_data;
          prt_pkg::SEL_CONTROL: begin
            enable_d     = req_i.write_data[prt_pkg::CtrlEnBit];
            period_sel_d = req_i.write_data[1:0];
          end
          default: count_d = count_q;
        endcase
      end
      default: rsp_o = '0;
    endcase
  end

  // State registers advance only on an accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      modulo_q     <= '0;
      enable_q     <= 1'b0;
      period_sel_q <= '0;
      rem_q        <= '0;
    end else if (accept_i) begin
      count_q      <= count_d;
      modulo_q     <= modulo_d;
      enable_q     <= enable_d;
      period_sel_q <= period_sel_d;
      rem_q        <= rem_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/prescaled_reload_timer.sv
// Top level of the prescaled reload timer: input handshake, register file and
// the output register. Uses prt_pkg and prt_regs.
//
//   Channel  Direction  Signals                          Beat type
//   in       sink       in_valid_i, in_ready_o, in_data_i    prt_pkg::req_t
//   out      source     out_valid_o, out_ready_i, out_data_o prt_pkg::rsp_t
//
// Every request beat produces one response beat in the cycle after acceptance.
// A request is taken in every cycle while the output register is empty or
// is being drained, so the sustained rate is one beat per cycle.
// Reset clears the counter, modulo, control and remainder and empties the
// output register. A stalled output holds its beat and stops new requests.
`default_nettype none

module prescaled_reload_timer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  prt_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output prt_pkg::rsp_t out_data_o
);

  logic          accept;
  logic          out_valid_q;
  prt_pkg::rsp_t out_data_q;
  prt_pkg::rsp_t rsp;

  // Take a request whenever the output register frees up this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  prt_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (in_data_i),
    .rsp_o    (rsp)
  );

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// File: rtl/prt_checker.sv
// Port-level checker for the prescaled reload timer and its bind statement.
// Depends on prt_pkg and the prescaled_reload_timer ports.
`default_nettype none

module prt_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input prt_pkg::req_t in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input prt_pkg::rsp_t out_data_o
);

  // A stalled response beat stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("response beat dropped while stalled");

  // A stalled response beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("response payload changed while stalled");

  // Every accepted request yields a response in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted request produced no response");

  // Only tick requests can raise the overflow interrupt.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.req_type != prt_pkg::REQ_TICK)
    |=> !out_data_o.overflow_irq)
    else $error("interrupt on a non-tick request");

  // Only read requests return nonzero read data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.req_type != prt_pkg::REQ_READ)
    |=> (out_data_o.read_data == '0))
    else $error("read data on a non-read request");

endmodule

bind prescaled_reload_timer prt_checker u_prt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// File: test/prescaled_reload_timer_tb.sv
// Self-checking testbench for prescaled_reload_timer: directed and random request beats
// with random idle gaps on both channels, checked against a cycle-free timer model.
// Depends on rtl/prt_pkg.sv and rtl/prescaled_reload_timer.sv.
`timescale 1ns / 1ps

module prescaled_reload_timer_tb;

  localparam logic [1:0] REQ_UNUSED  = 2'd3;
  localparam logic [1:0] SEL_UNUSED  = 2'd3;
  localparam int         MaxGap      = 18;
  localparam int         RandomItems = 1500;
  localparam int         DrainCycles = 16;
  localparam int         CycleLimit  = 400000;
  localparam int         RemFloor    = -2048;
  localparam int         RemCeil     = 2047;

  logic          clk_i;
  logic          rst_ni = 1'b0;
  logic          in_valid;
  logic          in_ready_o;
  prt_pkg::req_t in_data;
  logic          out_valid_o;
  logic          out_ready;
  prt_pkg::rsp_t out_data_o;

  prescaled_reload_timer u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o)
  );

  // Request beats waiting to be sent, and responses owed by the block in order.
  prt_pkg::req_t req_backlog[$];
  prt_pkg::rsp_t due_rsps[$];

  // Timer state as the block should hold it.
  logic [7:0] tmr_count;
  logic [7:0] tmr_modulo;
  logic       tmr_enable;
  logic [1:0] tmr_psel;
  int         tmr_rem;
  int         period_cycles[4] = '{1024, 16, 64, 256};

  int mismatches = 0;
  int n_checked  = 0;
  int n_accepted = 0;
  int n_irq      = 0;
  int n_ticks    = 0;
  int cycles     = 0;

  function automatic int clamp_rem(int v);
    if (v < RemFloor) return RemFloor;
    if (v > RemCeil) return RemCeil;
    return v;
  endfunction

  // Apply one request to the timer state and return the response it earns.
  function automatic prt_pkg::rsp_t timer_step(prt_pkg::req_t r);
    prt_pkg::rsp_t rsp;
    int            rem;
    rsp = '0;
    case (r.req_type)
      prt_pkg::REQ_TICK: begin
        if (tmr_enable) begin
          rem = clamp_rem(tmr_rem - int'(r.elapsed_cycles));
          if (rem <= 0) begin
            rem = clamp_rem(rem + period_cycles[tmr_psel]);
            if (tmr_count == 8'hFF) begin
              tmr_count = tmr_modulo;
              rsp.overflow_irq = 1'b1;
            end else begin
              tmr_count = tmr_count + 8'd1;
            end
          end
          tmr_rem = rem;
        end
      end
      prt_pkg::REQ_READ: begin
        case (r.reg_select)
          prt_pkg::SEL_COUNT:  rsp.read_data = tmr_count;
          prt_pkg::SEL_MODULO: rsp.read_data = tmr_modulo;
          prt_pkg::SEL_CONTROL: begin
            rsp.read_data[prt_pkg::CtrlEnBit] = tmr_enable;
            rsp.read_data[1:0] = tmr_psel;
          end
          default: rsp.read_data = '0;
        endcase
      end
      prt_pkg::REQ_WRITE: begin
        case (r.reg_select)
          prt_pkg::SEL_COUNT:  tmr_count = r.write_data;
          prt_pkg::SEL_MODULO: tmr_modulo = r.write_data;
          prt_pkg::SEL_CONTROL: begin
            tmr_enable = r.write_data[prt_pkg::CtrlEnBit];
            tmr_psel = r.write_data[1:0];
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    return rsp;
  endfunction

  task automatic add_req(logic [1:0] kind, logic [1:0] sel, logic [7:0] wdata,
                         logic [7:0] elapsed);
    prt_pkg::req_t r;
    r.req_type = kind;
    r.reg_select = sel;
    r.write_data = wdata;
    r.elapsed_cycles = elapsed;
    req_backlog.insert(req_backlog.size(), r);
  endtask

  // Random request mix: mostly enabled ticks, with writes biased so the counter
  // sits near the top and wraps often.
  task automatic add_random_req();
    prt_pkg::req_t r;
    int            pick;
    r = prt_pkg::req_t'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      r.req_type = prt_pkg::REQ_TICK;
      if ($urandom_range(0, 3) != 0) r.elapsed_cycles = 8'($urandom_range(0, 40));
    end else if (pick < 70) begin
      r.req_type = prt_pkg::REQ_READ;
    end else if (pick < 90) begin
      r.req_type = prt_pkg::REQ_WRITE;
      case (r.reg_select)
        prt_pkg::SEL_COUNT: begin
          if ($urandom_range(0, 3) != 0) r.write_data = 8'($urandom_range(8'hE0, 8'hFF));
        end
        prt_pkg::SEL_MODULO: begin
          if ($urandom_range(0, 4) < 3) r.write_data = 8'($urandom_range(8'hC0, 8'hFF));
        end
        prt_pkg::SEL_CONTROL: begin
          if ($urandom_range(0, 4) != 0) r.write_data[prt_pkg::CtrlEnBit] = 1'b1;
          if ($urandom_range(0, 1) != 0) r.write_data[1:0] = prt_pkg::SEL_MODULO;
        end
        default: ;
      endcase
    end else if (pick < 94) begin
      r.req_type = REQ_UNUSED;
    end else begin
      // Long ticks drive the remainder into its lower saturation.
      r.req_type = prt_pkg::REQ_TICK;
      r.elapsed_cycles = 8'hFF;
    end
    req_backlog.insert(req_backlog.size(), r);
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Request driver: sends backlog beats with a random gap drawn per beat.
  int in_gap;
  bit in_burst;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      in_gap   <= 0;
      in_burst <= 1'b0;
    end else if (!in_valid || in_ready_o) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (req_backlog.size() != 0) begin
        in_data  <= req_backlog.pop_front();
        in_valid <= 1'b1;
        in_gap   <= in_burst ? 0 : $urandom_range(0, MaxGap);
        if ($urandom_range(0, 31) == 0) in_burst <= ~in_burst;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Response monitor: predicts on each accepted request, checks each accepted
  // response, and stalls the output channel at random.
  int out_stall;
  bit out_burst;
  always @(posedge clk_i or negedge rst_ni) begin
    prt_pkg::rsp_t exp_rsp;
    int            s;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      out_stall <= 0;
      out_burst <= 1'b0;
      tmr_count  = '0;
      tmr_modulo = '0;
      tmr_enable = 1'b0;
      tmr_psel   = '0;
      tmr_rem    = 0;
    end else begin
      if (in_valid && in_ready_o) begin
        due_rsps.insert(due_rsps.size(), timer_step(in_data));
        n_accepted++;
        if (in_data.req_type == prt_pkg::REQ_TICK) n_ticks++;
      end
      if (out_valid_o && out_ready) begin
        if (due_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: response beat with nothing outstanding: data=%02h irq=%0b",
                     out_data_o.read_data, out_data_o.overflow_irq);
        end else begin
          exp_rsp = due_rsps.pop_front();
          n_checked++;
          if (out_data_o.overflow_irq) n_irq++;
          if (out_data_o.read_data !== exp_rsp.read_data ||
              out_data_o.overflow_irq !== exp_rsp.overflow_irq) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: beat %0d: expected data=%02h irq=%0b, got data=%02h irq=%0b",
                       n_checked, exp_rsp.read_data, exp_rsp.overflow_irq,
                       out_data_o.read_data, out_data_o.overflow_irq);
          end
        end
        s = out_burst ? 0 : $urandom_range(0, MaxGap);
        if ($urandom_range(0, 31) == 0) out_burst <= ~out_burst;
        out_stall <= s;
        out_ready <= (s == 0);
      end else if (out_stall != 0) begin
        out_stall <= out_stall - 1;
        out_ready <= (out_stall == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d responses outstanding", cycles,
               due_rsps.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    // Reset values, unused selector and unused request code.
    add_req(prt_pkg::REQ_READ, prt_pkg::SEL_COUNT, 8'h00, 8'h00);
    add_req(prt_pkg::REQ_READ, prt_pkg::SEL_MODULO, 8'h00, 8'h00);
    add_req(prt_pkg::REQ_READ, prt_pkg::SEL_CONTROL, 8'h00, 8'h00);
    add_req(prt_pkg::REQ_READ, SEL_UNUSED, 8'hFF, 8'hFF);
    add_req(prt_pkg::REQ_WRITE, prt_pkg::SEL_COUNT, 8'hFF, 8'h00);
    add_req(prt_pkg::REQ_WRITE, prt_pkg::SEL_MODULO, 8'hAB, 8'h00);
    add_req(prt_pkg::REQ_WRITE, SEL_UNUSED, 8'hFF, 8'hFF);
    add_req(REQ_UNUSED, SEL_UNUSED, 8'hFF, 8'hFF);
    // A tick while disabled leaves the counter alone.
    add_req(prt_pkg::REQ_TICK, prt_pkg::SEL_COUNT, 8'h00, 8'hFF);
    add_req(prt_pkg::REQ_READ, prt_pkg::SEL_COUNT, 8'h00, 8'h00);
    // Enable with period select code 1; a zero tick wraps from 0xFF and reloads.
    add_req(prt_pkg::REQ_WRITE, prt_pkg::SEL_CONTROL, 8'h05, 8'h00);
    add_req(prt_pkg::REQ_READ, prt_pkg::SEL_CONTROL, 8'h00, 8'h00);
    add_req(prt_pkg::REQ_TICK, prt_pkg::SEL_COUNT, 8'h00, 8'h00);
    // Ticks much longer than the period step once each and saturate low.
    repeat (9) add_req(prt_pkg::REQ_TICK, prt_pkg::SEL_COUNT, 8'h00, 8'hFF);
    // Stray control bits are dropped; the enable bit clears and the period select goes back to code 0.
    add_req(prt_pkg::REQ_WRITE, prt_pkg::SEL_CONTROL, 8'hF8, 8'h00);
    add_req(prt_pkg::REQ_READ, prt_pkg::SEL_CONTROL, 8'h00, 8'h00);
    add_req(prt_pkg::REQ_WRITE, prt_pkg::SEL_COUNT, 8'h00, 8'h00);
    repeat (RandomItems) add_random_req();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_backlog.size() != 0 || in_valid || due_rsps.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (due_rsps.size() != 0) begin
      mismatches++;
      $display("ERROR: %0d responses never arrived", due_rsps.size());
    end
    $display("Checked %0d of %0d request beats (%0d ticks), %0d overflow interrupts seen.",
             n_checked, n_accepted, n_ticks, n_irq);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: prescaled_reload_timer.f
rtl/prt_pkg.sv
rtl/prt_prescale.sv
rtl/prt_regs.sv
rtl/prescaled_reload_timer.sv
rtl/prt_checker.sv
test/prescaled_reload_timer_tb.sv
